// ===== hdl/gbi_pkg.sv =====
// Shared types, widths and codes for the grid bilinear interpolator.
package gbi_pkg;

  localparam int GRID_SIZE   = 32;
  localparam int IDX_W       = $clog2(GRID_SIZE);
  localparam int HALF_W      = IDX_W - 1;
  localparam int BANK_DEPTH  = (GRID_SIZE / 2) * (GRID_SIZE / 2);
  localparam int BANK_AW     = 2 * HALF_W;
  localparam int NUM_BANKS   = 4;

  localparam int FRAC_W      = 16;
  localparam int Q_ONE       = 65536;
  localparam int Q_HALF      = 32768;

  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 16;
  localparam int CELLS_W     = 6;

  localparam int NC_W        = $clog2(GRID_SIZE + 3);
  localparam int PX_W        = 32;
  localparam int GC_W        = NC_W + FRAC_W;
  localparam int T_FULL_W    = GC_W + 2;

  localparam int SAMP_W      = 32;
  localparam int W_W         = 19;
  localparam int PROD_W      = SAMP_W + W_W;
  localparam int SUM1_W      = PROD_W + 1;
  localparam int R_W         = SUM1_W - FRAC_W;
  localparam int Q_W         = R_W + W_W;
  localparam int SUM2_W      = Q_W + 1;

  localparam int FIFO_DEPTH  = 16;
  localparam int PTR_W       = $clog2(FIFO_DEPTH);
  localparam int CNT_W       = $clog2(FIFO_DEPTH + 1);

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  localparam logic ST_OK    = 1'b0;
  localparam logic ST_RANGE = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_RANGE_LIMIT    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CELLS_PER_UNIT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CELLS_IN_USE   = 2'd2;

  typedef struct packed {
    logic                     opcode;
    logic [4:0]               row;
    logic [4:0]               col;
    logic signed [SAMP_W-1:0] entry_value;
    logic [15:0]              coord_x;
    logic [15:0]              coord_y;
  } in_beat_t;

  typedef struct packed {
    logic signed [SAMP_W-1:0] value;
    logic                     status;
  } out_beat_t;

  typedef struct packed {
    logic                     wr_en;
    logic                     rd_en;
    logic [IDX_W-1:0]         row;
    logic [IDX_W-1:0]         col;
    logic signed [SAMP_W-1:0] data;
  } mem_req_t;

  typedef struct packed {
    logic signed [SAMP_W-1:0] s00;
    logic signed [SAMP_W-1:0] s10;
    logic signed [SAMP_W-1:0] s01;
    logic signed [SAMP_W-1:0] s11;
  } quad_t;

  typedef struct packed {
    logic valid;
    logic live;
    logic status;
  } ctl_t;

endpackage

// ===== hdl/gbi_grid_mem.sv =====
// Grid sample store split into four row/column parity banks with registered reads.
module gbi_grid_mem import gbi_pkg::*; (
  input  logic     clk,
  input  mem_req_t req,
  output quad_t    quad
);

  logic signed [SAMP_W-1:0] rd_q_r [NUM_BANKS];
  logic                     x0p_r;
  logic                     y0p_r;
  logic [IDX_W-1:0]         x1;
  logic [IDX_W-1:0]         y1;
  logic [1:0]               wr_bank;
  logic [BANK_AW-1:0]       wr_addr;

  assign x1      = req.row + IDX_W'(1);
  assign y1      = req.col + IDX_W'(1);
  assign wr_bank = {req.row[0], req.col[0]};
  assign wr_addr = {req.row[IDX_W-1:1], req.col[IDX_W-1:1]};

  for (genvar b = 0; b < NUM_BANKS; b++) begin : g_bank
    localparam logic PX = 1'((b >> 1) & 1);
    localparam logic PY = 1'(b & 1);

    logic signed [SAMP_W-1:0] mem [BANK_DEPTH];
    logic [IDX_W-1:0]         rsel;
    logic [IDX_W-1:0]         csel;
    logic [BANK_AW-1:0]       rd_addr;

    assign rsel    = (req.row[0] == PX) ? req.row : x1;
    assign csel    = (req.col[0] == PY) ? req.col : y1;
    assign rd_addr = {rsel[IDX_W-1:1], csel[IDX_W-1:1]};

    always_ff @(posedge clk) begin
      if (req.wr_en && (wr_bank == 2'(b))) begin
        mem[wr_addr] <= req.data;
      end
      if (req.rd_en) begin
        rd_q_r[b] <= mem[rd_addr];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      x0p_r <= req.row[0];
      y0p_r <= req.col[0];
    end
  end

  assign quad.s00 = rd_q_r[{x0p_r, y0p_r}];
  assign quad.s10 = rd_q_r[{~x0p_r, y0p_r}];
  assign quad.s01 = rd_q_r[{x0p_r, ~y0p_r}];
  assign quad.s11 = rd_q_r[{~x0p_r, ~y0p_r}];

endmodule

// ===== hdl/gbi_blend.sv =====
// Weighted blend pipeline: x products, x round, y products, y round and saturate.
module gbi_blend import gbi_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  ctl_t                  c_ctl,
  input  quad_t                 quad,
  input  logic signed [W_W-1:0] t,
  input  logic signed [W_W-1:0] u,
  output logic                  push,
  output out_beat_t             push_beat
);

  localparam logic signed [SUM2_W-1:0] SAT_HI = SUM2_W'(32'sh7FFFFFFF);
  localparam logic signed [SUM2_W-1:0] SAT_LO = SUM2_W'(32'sh80000000);

  ctl_t                     d_ctl_r;
  ctl_t                     e_ctl_r;
  ctl_t                     f_ctl_r;
  logic signed [PROD_W-1:0] p00_r, p10_r, p01_r, p11_r;
  logic signed [W_W-1:0]    d_u_r;
  logic signed [W_W-1:0]    e_u_r;
  logic signed [R_W-1:0]    r0_r, r1_r;
  logic signed [Q_W-1:0]    q0_r, q1_r;

  logic signed [W_W-1:0]    omt;
  logic signed [W_W-1:0]    omu;
  logic signed [SUM1_W-1:0] sum_r0;
  logic signed [SUM1_W-1:0] sum_r1;
  logic signed [SUM2_W-1:0] sum_y;
  logic signed [SUM2_W-1:0] sh_y;
  logic signed [SAMP_W-1:0] sat;

  assign omt = W_W'(Q_ONE) - t;
  assign omu = W_W'(Q_ONE) - e_u_r;

  assign sum_r0 = SUM1_W'(p00_r) + SUM1_W'(p10_r) + SUM1_W'(Q_HALF);
  assign sum_r1 = SUM1_W'(p01_r) + SUM1_W'(p11_r) + SUM1_W'(Q_HALF);

  assign sum_y = SUM2_W'(q0_r) + SUM2_W'(q1_r) + SUM2_W'(Q_HALF);
  assign sh_y  = sum_y >>> FRAC_W;

  always_comb begin
    priority if (sh_y > SAT_HI) begin
      sat = 32'sh7FFFFFFF;
    end else if (sh_y < SAT_LO) begin
      sat = 32'sh80000000;
    end else begin
      sat = SAMP_W'(sh_y);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_ctl_r <= '0;
      e_ctl_r <= '0;
      f_ctl_r <= '0;
    end else begin
      d_ctl_r <= c_ctl;
      e_ctl_r <= d_ctl_r;
      f_ctl_r <= e_ctl_r;
    end
  end

  always_ff @(posedge clk) begin
    p00_r <= PROD_W'(quad.s00) * PROD_W'(omt);
    p10_r <= PROD_W'(quad.s10) * PROD_W'(t);
    p01_r <= PROD_W'(quad.s01) * PROD_W'(omt);
    p11_r <= PROD_W'(quad.s11) * PROD_W'(t);
    d_u_r <= u;
    r0_r  <= R_W'(sum_r0 >>> FRAC_W);
    r1_r  <= R_W'(sum_r1 >>> FRAC_W);
    e_u_r <= d_u_r;
    q0_r  <= Q_W'(r0_r) * Q_W'(omu);
    q1_r  <= Q_W'(r1_r) * Q_W'(e_u_r);
  end

  assign push             = f_ctl_r.valid;
  assign push_beat.value  = f_ctl_r.live ? sat : '0;
  assign push_beat.status = f_ctl_r.status;

endmodule

// ===== hdl/gbi_out_fifo.sv =====
// Output result queue that decouples the pipeline from the result stall.
module gbi_out_fifo import gbi_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  out_beat_t push_beat,
  input  logic      out_stall,
  output logic      out_valid,
  output out_beat_t out_beat,
  output logic      pop
);

  out_beat_t        store_r [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;

  assign out_valid = (count_r != '0);
  assign out_beat  = store_r[rd_ptr_r];
  assign pop       = out_valid && !out_stall;

  assign count_nxt = count_r + CNT_W'(push) - CNT_W'(pop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + PTR_W'(1);
      end
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      store_r[wr_ptr_r] <= push_beat;
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (count_r < CNT_W'(FIFO_DEPTH)))
    else $error("result queue written while full");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(FIFO_DEPTH))
    else $error("result queue count out of range");

  a_pop_drains: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && !push) |=> (count_r == $past(count_r) - CNT_W'(1)))
    else $error("result queue count did not drop on pop");
`endif

endmodule

// ===== hdl/grid_bilinear_interpolator.sv =====
// Top level of the grid bilinear interpolator: config, coordinate mapping, grid access, blend, output queue.
//
// Accepts one beat per clock while input stall is low, write or query, and returns one result
// beat per input beat in order. Stages A and B map each coordinate to grid units, and the lower
// cell index follows from stage B; a registered read fetches the four neighbors from four
// row/column parity banks (one read port each, so all four neighbors come in the same cycle),
// and the blend pipeline weights along x and then y. Results collect in a 16-beat output queue;
// input stall rises only when the queue plus beats in flight would fill it, so input keeps
// flowing while a result waits. Grid entries are undefined after reset until written; there is
// no clearing pass. Configuration writes are taken every cycle and are meant for idle periods.
module grid_bilinear_interpolator import gbi_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_beat_t              in_beat,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_beat_t             out_beat,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  typedef struct packed {
    logic [IDX_W-1:0]      x0;
    logic signed [W_W-1:0] w;
  } loc_t;

  logic [15:0]        range_limit_r;
  logic [15:0]        cells_per_unit_r;
  logic [CELLS_W-1:0] cells_in_use_r;
  logic [NC_W-1:0]    n_cells;
  logic [GC_W-1:0]    g_max;

  logic               accept;
  logic               pop;
  logic [CNT_W-1:0]   credit_r;
  logic [CNT_W-1:0]   credit_nxt;
  logic               in_stall_r;

  logic                     a_valid_r;
  logic                     a_op_r;
  logic                     a_err_r;
  logic [4:0]               a_row_r;
  logic [4:0]               a_col_r;
  logic signed [SAMP_W-1:0] a_data_r;
  logic [PX_W-1:0]          a_px_r;
  logic [PX_W-1:0]          a_py_r;

  logic                     b_valid_r;
  logic                     b_op_r;
  logic                     b_err_r;
  logic [4:0]               b_row_r;
  logic [4:0]               b_col_r;
  logic signed [SAMP_W-1:0] b_data_r;
  logic [GC_W-1:0]          b_gx_r;
  logic [GC_W-1:0]          b_gy_r;

  loc_t                     loc_x;
  loc_t                     loc_y;
  mem_req_t                 req;
  ctl_t                     c_ctl_r;
  logic signed [W_W-1:0]    c_t_r;
  logic signed [W_W-1:0]    c_u_r;
  quad_t                    quad;
  logic                     push;
  out_beat_t                push_beat;
  logic                     b_query;
  logic                     b_wr_in_grid;

  function automatic logic [GC_W-1:0] clamp_g(input logic [PX_W-1:0] p,
                                               input logic [GC_W-1:0] gmax);
    logic [PX_W:0] g;
    g = {1'b0, p} + (PX_W + 1)'(Q_ONE);
    if (g > (PX_W + 1)'(gmax)) begin
      return gmax;
    end
    return GC_W'(g);
  endfunction

  function automatic loc_t locate(input logic [GC_W-1:0] gc, input logic [NC_W-1:0] n);
    logic [GC_W-1:0]            rnd;
    logic [NC_W-1:0]            ip;
    logic signed [T_FULL_W-1:0] tf;
    loc_t                       loc;
    rnd = gc + GC_W'(Q_HALF);
    ip  = rnd[GC_W-1:FRAC_W] - NC_W'(1);
    priority if (ip < NC_W'(1)) begin
      ip = NC_W'(1);
    end else if (ip > n - NC_W'(1)) begin
      ip = n - NC_W'(1);
    end
    tf = $signed({2'b00, gc}) - $signed({2'b00, ip, FRAC_W'(0)}) - T_FULL_W'(Q_HALF);
    loc.x0 = IDX_W'(ip - NC_W'(1));
    loc.w  = W_W'(tf);
    return loc;
  endfunction

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      range_limit_r    <= 16'hFFFF;
      cells_per_unit_r <= 16'h1000;
      cells_in_use_r   <= CELLS_W'(32);
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_RANGE_LIMIT:    range_limit_r    <= cfg_data;
        CFG_CELLS_PER_UNIT: cells_per_unit_r <= cfg_data;
        CFG_CELLS_IN_USE:   cells_in_use_r   <= cfg_data[CELLS_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    priority if (int'(cells_in_use_r) < 2) begin
      n_cells = NC_W'(2);
    end else if (int'(cells_in_use_r) > GRID_SIZE) begin
      n_cells = NC_W'(GRID_SIZE);
    end else begin
      n_cells = NC_W'(cells_in_use_r);
    end
  end

  assign g_max = {n_cells + NC_W'(2), FRAC_W'(0)};

  assign accept     = in_valid && !in_stall_r;
  assign in_stall   = in_stall_r;
  assign credit_nxt = credit_r + CNT_W'(accept) - CNT_W'(pop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      credit_r   <= '0;
      in_stall_r <= 1'b1;
    end else begin
      credit_r   <= credit_nxt;
      in_stall_r <= (credit_nxt >= CNT_W'(FIFO_DEPTH));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      b_valid_r <= 1'b0;
      c_ctl_r   <= '0;
    end else begin
      a_valid_r      <= accept;
      b_valid_r      <= a_valid_r;
      c_ctl_r.valid  <= b_valid_r;
      c_ctl_r.live   <= b_query && !b_err_r;
      c_ctl_r.status <= b_query && b_err_r ? ST_RANGE : ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    a_op_r   <= in_beat.opcode;
    a_err_r  <= (in_beat.coord_x > range_limit_r) || (in_beat.coord_y > range_limit_r);
    a_row_r  <= in_beat.row;
    a_col_r  <= in_beat.col;
    a_data_r <= in_beat.entry_value;
    a_px_r   <= PX_W'(in_beat.coord_x) * PX_W'(cells_per_unit_r);
    a_py_r   <= PX_W'(in_beat.coord_y) * PX_W'(cells_per_unit_r);

    b_op_r   <= a_op_r;
    b_err_r  <= a_err_r;
    b_row_r  <= a_row_r;
    b_col_r  <= a_col_r;
    b_data_r <= a_data_r;
    b_gx_r   <= clamp_g(a_px_r, g_max);
    b_gy_r   <= clamp_g(a_py_r, g_max);

    c_t_r    <= loc_x.w;
    c_u_r    <= loc_y.w;
  end

  assign loc_x        = locate(b_gx_r, n_cells);
  assign loc_y        = locate(b_gy_r, n_cells);
  assign b_query      = (b_op_r == OP_QUERY);
  assign b_wr_in_grid = (int'(b_row_r) < GRID_SIZE) && (int'(b_col_r) < GRID_SIZE);

  always_comb begin
    req.wr_en = b_valid_r && !b_query && b_wr_in_grid;
    req.rd_en = b_valid_r && b_query && !b_err_r;
    req.data  = b_data_r;
    if (b_query) begin
      req.row = loc_x.x0;
      req.col = loc_y.x0;
    end else begin
      req.row = IDX_W'(b_row_r);
      req.col = IDX_W'(b_col_r);
    end
  end

  gbi_grid_mem u_mem (
    .clk  (clk),
    .req  (req),
    .quad (quad)
  );

  gbi_blend u_blend (
    .clk       (clk),
    .rst_n     (rst_n),
    .c_ctl     (c_ctl_r),
    .quad      (quad),
    .t         (c_t_r),
    .u         (c_u_r),
    .push      (push),
    .push_beat (push_beat)
  );

  gbi_out_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_beat (push_beat),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_beat  (out_beat),
    .pop       (pop)
  );

endmodule
